>>> design/deferred_interrupt_dispatcher_top_macros.svh
// ----------------------------------------------------------------------------
// Deferred interrupt dispatcher assertion macros
// Shared concurrent assertion forms for the dispatcher modules.
// ----------------------------------------------------------------------------
`ifndef DEFERRED_INTERRUPT_DISPATCHER_TOP_MACROS_SVH
`define DEFERRED_INTERRUPT_DISPATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DID_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DID_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

>>> design/did_pkg.sv
// ----------------------------------------------------------------------------
// Deferred interrupt dispatcher package
// Command codes, fixed field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package did_pkg;

	localparam int CMD_W         = 2;
	localparam int LINE_FIELD_W  = 5;
	localparam int COUNT_FIELD_W = 16;
	localparam int HANDLER_W     = 32;

	localparam logic [CMD_W-1:0] CMD_EVENT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SAVE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic ev_read;
		logic ev_write;
		logic restore_wr;
		logic drop_unhandled;
		logic pick;
		logic load_dispatch;
		logic load_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             line_ok;
		logic             flag;
		logic             pend_any;
		logic             pick_last;
		logic             out_free;
	} dp_status_t;

endpackage

>>> design/did_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module did_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/did_datapath.sv
// ----------------------------------------------------------------------------
// Deferred interrupt dispatcher datapath
// Pending mask, soft-disable flag, occurrence counters and the result register.
// ----------------------------------------------------------------------------
`include "deferred_interrupt_dispatcher_top_macros.svh"

module did_datapath #(
	parameter int LINE_COUNT = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  did_pkg::ctrl_cmd_t                   cmd,
	output did_pkg::dp_status_t                  sts,
	input  logic [did_pkg::CMD_W-1:0]            command,
	input  logic [did_pkg::LINE_FIELD_W-1:0]     irq_line,
	input  logic                                 restore_value,
	input  logic                                 cfg_write_en,
	input  logic [did_pkg::HANDLER_W-1:0]        handler_present,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic                                 dispatch_valid,
	output logic [did_pkg::LINE_FIELD_W-1:0]     dispatched_line,
	output logic [did_pkg::COUNT_FIELD_W-1:0]    occurrence_count,
	output logic                                 old_save_flag,
	output logic                                 last_result
);

	localparam int LINE_BITS = $clog2(LINE_COUNT);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [did_pkg::CMD_W-1:0]        cmd_q;
	logic [did_pkg::LINE_FIELD_W-1:0] line_q;
	logic                             val_q;
	logic [LINE_COUNT-1:0]            handler_q;
	logic [LINE_COUNT-1:0]            pending_q;
	logic [LINE_COUNT-1:0]            cnt_vld_q;
	logic                             flag_q;
	logic [LINE_BITS-1:0]             pick_q;
	logic                             last_q;
	logic                             out_valid_q;

	logic [LINE_BITS-1:0]  line_idx;
	logic [LINE_BITS-1:0]  pick_idx;
	logic [LINE_COUNT-1:0] pick_bit;
	logic                  ram_re;
	logic [LINE_BITS-1:0]  ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cur_count;
	logic [COUNT_BITS-1:0] next_count;
	logic [COUNT_BITS-1:0] disp_count;
	logic [63:0]           disp_count_ext;
	logic                  out_free;

	assign line_idx = line_q[LINE_BITS-1:0];

	// Highest pending line wins.
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			if (pending_q[i]) begin
				pick_idx = LINE_BITS'(i);
			end
		end
	end

	always_comb begin
		pick_bit = '0;
		pick_bit[pick_idx] = 1'b1;
	end

	assign ram_re    = cmd.ev_read | cmd.pick;
	assign ram_raddr = cmd.pick ? pick_idx : line_idx;

	// A counter that was never written since its last dispatch reads as zero.
	assign cur_count  = cnt_vld_q[line_idx] ? ram_rdata : '0;
	assign next_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
	assign disp_count = cnt_vld_q[pick_q] ? ram_rdata : '0;
	assign disp_count_ext = 64'(disp_count);

	did_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (LINE_COUNT)
	) u_counters (
		.clk   (clk),
		.we    (cmd.ev_write),
		.waddr (line_idx),
		.wdata (next_count),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			line_q <= irq_line;
			val_q  <= restore_value;
		end
		if (cmd.pick) begin
			pick_q <= pick_idx;
			last_q <= ((pending_q & ~pick_bit) == '0);
		end
		if (cmd.load_dispatch) begin
			dispatch_valid   <= 1'b1;
			dispatched_line  <= did_pkg::LINE_FIELD_W'(pick_q);
			occurrence_count <= disp_count_ext[did_pkg::COUNT_FIELD_W-1:0];
			old_save_flag    <= flag_q;
			last_result      <= last_q;
		end else if (cmd.load_status) begin
			dispatch_valid   <= 1'b0;
			dispatched_line  <= '0;
			occurrence_count <= '0;
			old_save_flag    <= flag_q;
			last_result      <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q   <= '0;
			pending_q   <= '0;
			cnt_vld_q   <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				handler_q <= handler_present[LINE_COUNT-1:0];
			end
			if (cmd.ev_write) begin
				pending_q[line_idx] <= 1'b1;
				cnt_vld_q[line_idx] <= 1'b1;
			end
			if (cmd.restore_wr) begin
				flag_q <= val_q;
			end
			// Lines without a handler simply lose their pending bit.
			if (cmd.drop_unhandled) begin
				pending_q <= pending_q & handler_q;
			end
			if (cmd.pick) begin
				pending_q <= pending_q & ~pick_bit;
			end
			if (cmd.load_dispatch) begin
				cnt_vld_q[pick_q] <= 1'b0;
			end
			// A save reports the old flag, then sets it.
			if (cmd.load_status && (cmd_q == did_pkg::CMD_SAVE)) begin
				flag_q <= 1'b1;
			end
			if (cmd.load_dispatch || cmd.load_status) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign sts.command   = cmd_q;
	assign sts.line_ok   = ({1'b0, line_q} < (did_pkg::LINE_FIELD_W + 1)'(LINE_COUNT));
	assign sts.flag      = flag_q;
	assign sts.pend_any  = (pending_q != '0);
	assign sts.pick_last = last_q;
	assign sts.out_free  = out_free;

	// A dispatched line is only ever handed over while the flag is clear.
	`DID_ASSERT_SAME(a_dispatch_unmasked, clk, arst_n,
		out_valid_q && dispatch_valid, !old_save_flag)

endmodule

>>> design/did_ctrl.sv
// ----------------------------------------------------------------------------
// Deferred interrupt dispatcher controller
// Sequences command execution, counter updates and the drain of pending lines.
// ----------------------------------------------------------------------------
`include "deferred_interrupt_dispatcher_top_macros.svh"

module did_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  did_pkg::dp_status_t sts,
	output did_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_EV_WR  = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_DR_OUT = 3'd5;
	localparam logic [2:0] ST_STATUS = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.command)
					did_pkg::CMD_EVENT: begin
						if (sts.line_ok) begin
							cmd.ev_read = 1'b1;
							state_d     = ST_EV_WR;
						end else begin
							state_d = ST_CHECK;
						end
					end
					did_pkg::CMD_RESTORE: begin
						cmd.restore_wr = 1'b1;
						state_d        = ST_CHECK;
					end
					default: begin
						state_d = ST_STATUS;
					end
				endcase
			end
			ST_EV_WR: begin
				cmd.ev_write = 1'b1;
				state_d      = ST_CHECK;
			end
			ST_CHECK: begin
				if (!sts.flag) begin
					cmd.drop_unhandled = 1'b1;
					state_d            = ST_DRAIN;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_DRAIN: begin
				if (sts.pend_any) begin
					cmd.pick = 1'b1;
					state_d  = ST_DR_OUT;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_DR_OUT: begin
				if (sts.out_free) begin
					cmd.load_dispatch = 1'b1;
					state_d           = sts.pick_last ? ST_IDLE : ST_DRAIN;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) begin
					cmd.load_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Every drain empties the pending mask, so an unmasked idle block has none left.
	`DID_ASSERT_SAME(a_idle_drained, clk, arst_n,
		(state_q == ST_IDLE) && !sts.flag, !sts.pend_any)
	`DID_ASSERT_NEXT(a_last_ends_item, clk, arst_n,
		cmd.load_dispatch && sts.pick_last, state_q == ST_IDLE)
	`DID_ASSERT_NEXT(a_accept_starts, clk, arst_n,
		in_valid && !in_stall, state_q == ST_EXEC)

endmodule

>>> design/deferred_interrupt_dispatcher_top.sv
// ----------------------------------------------------------------------------
// Deferred interrupt dispatcher
// One item is taken at a time. A save or an unknown command goes straight
// to a status result. A restore writes the flag, an in-range event updates
// its line's counter; both then drain the pending lines unless the flag is
// set. Each dispatched line is first picked as the highest pending line,
// with its counter read from the counter RAM, then loaded into the result
// register; that load waits while out_stall holds the output. The counter
// RAM has a single read port, so an event's counter read-modify-write and
// each dispatch take separate states. Counters clear through per-line
// valid bits at reset; no clearing pass is needed. handler_present may be
// written only while idle.
// ----------------------------------------------------------------------------
module deferred_interrupt_dispatcher_top #(
	parameter int LINE_COUNT = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [did_pkg::CMD_W-1:0]         command,
	input  logic [did_pkg::LINE_FIELD_W-1:0]  irq_line,
	input  logic                              restore_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              dispatch_valid,
	output logic [did_pkg::LINE_FIELD_W-1:0]  dispatched_line,
	output logic [did_pkg::COUNT_FIELD_W-1:0] occurrence_count,
	output logic                              old_save_flag,
	output logic                              last_result,
	input  logic                              cfg_write_en,
	input  logic [did_pkg::HANDLER_W-1:0]     handler_present
);

	did_pkg::ctrl_cmd_t  cmd;
	did_pkg::dp_status_t sts;

	did_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	did_datapath #(
		.LINE_COUNT (LINE_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.command          (command),
		.irq_line         (irq_line),
		.restore_value    (restore_value),
		.cfg_write_en     (cfg_write_en),
		.handler_present  (handler_present),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.dispatch_valid   (dispatch_valid),
		.dispatched_line  (dispatched_line),
		.occurrence_count (occurrence_count),
		.old_save_flag    (old_save_flag),
		.last_result      (last_result)
	);

endmodule
